// ===== hdl/sorted_group_membership_table_macros.svh =====
// Assertion macros for the sorted group membership table.
// Used by the checker; depends on nothing else.
`ifndef SORTED_GROUP_MEMBERSHIP_TABLE_MACROS_SVH
`define SORTED_GROUP_MEMBERSHIP_TABLE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SGMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SGMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sgmt_pkg.sv =====
// Shared types and constants of the sorted group membership table.
// Used by every module of the block but the RAM; depends on nothing.
`default_nettype none

package sgmt_pkg;

    localparam int unsigned MAX_GROUPS_DEF  = 64;
    localparam int unsigned MAX_MEMBERS_DEF = 16;
    localparam logic [6:0]  LIMIT_RESET     = 7'd64;

    localparam logic [2:0] FN_REGISTER = 3'd0;
    localparam logic [2:0] FN_ADD      = 3'd1;
    localparam logic [2:0] FN_REMOVE   = 3'd2;
    localparam logic [2:0] FN_HAS      = 3'd3;
    localparam logic [2:0] FN_FIND     = 3'd4;

    localparam logic [2:0] ADDR_LIMIT = 3'd0;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_TABLE_FULL = 3'd1,
        STAT_DUPLICATE  = 3'd2,
        STAT_NOT_FOUND  = 3'd3,
        STAT_GROUP_FULL = 3'd4,
        STAT_ABSENT     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_GSCAN, S_DECIDE, S_MRD, S_MCMP, S_MOP,
        S_UP, S_UPWR, S_DN, S_DNWR, S_DONE
    } t_state;

    // Commands broadcast to every cell of the group chain.
    typedef struct packed {
        logic rotate;
        logic ins;
        logic upd;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hdl/sgmt_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module sgmt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/sgmt_cell.sv =====
// One cell of the sorted group chain: a group's id, references, row and count.
// Depends on sgmt_pkg for the chain command struct.
`default_nettype none

module sgmt_cell #(
    parameter int unsigned SW = 6,
    parameter int unsigned CW = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sgmt_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic [63:0]           i_gid,
    input  wire logic [63:0]           i_new_res,
    input  wire logic [63:0]           i_new_pool,
    input  wire logic [SW-1:0]         i_new_slot,
    input  wire logic [CW-1:0]         i_new_cnt,
    input  wire logic                  i_prev_lt,
    input  wire logic                  i_prev_valid,
    input  wire logic [63:0]           i_prev_id,
    input  wire logic [63:0]           i_prev_res,
    input  wire logic [63:0]           i_prev_pool,
    input  wire logic [SW-1:0]         i_prev_slot,
    input  wire logic [CW-1:0]         i_prev_cnt,
    input  wire logic                  i_next_valid,
    input  wire logic [63:0]           i_next_id,
    input  wire logic [63:0]           i_next_res,
    input  wire logic [63:0]           i_next_pool,
    input  wire logic [SW-1:0]         i_next_slot,
    input  wire logic [CW-1:0]         i_next_cnt,
    output logic                       o_lt,
    output logic                       o_valid,
    output logic [63:0]                o_id,
    output logic [63:0]                o_res,
    output logic [63:0]                o_pool,
    output logic [SW-1:0]              o_slot,
    output logic [CW-1:0]              o_cnt
);

    logic          r_valid;
    logic [63:0]   r_id;
    logic [63:0]   r_res;
    logic [63:0]   r_pool;
    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_cnt;
    logic          w_match;
    logic          w_take_new;
    logic          w_take_prev;

    assign o_lt        = r_valid && (r_id < i_gid);
    assign w_match     = r_valid && (r_id == i_gid);
    assign w_take_new  = i_ctrl.ins && !o_lt && i_prev_lt;
    assign w_take_prev = i_ctrl.ins && !o_lt && !i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.rotate) begin
            r_valid <= i_next_valid;
        end else if (w_take_new) begin
            r_valid <= 1'b1;
        end else if (w_take_prev) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rotate) begin
            r_id   <= i_next_id;
            r_res  <= i_next_res;
            r_pool <= i_next_pool;
            r_slot <= i_next_slot;
            r_cnt  <= i_next_cnt;
        end else if (w_take_new) begin
            r_id   <= i_gid;
            r_res  <= i_new_res;
            r_pool <= i_new_pool;
            r_slot <= i_new_slot;
            r_cnt  <= '0;
        end else if (w_take_prev) begin
            r_id   <= i_prev_id;
            r_res  <= i_prev_res;
            r_pool <= i_prev_pool;
            r_slot <= i_prev_slot;
            r_cnt  <= i_prev_cnt;
        end else if (i_ctrl.upd && w_match) begin
            r_cnt <= i_new_cnt;
        end
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_res   = r_res;
    assign o_pool  = r_pool;
    assign o_slot  = r_slot;
    assign o_cnt   = r_cnt;

endmodule

`default_nettype wire

// ===== hdl/sorted_group_membership_table.sv =====
// Sorted group membership table: groups in ascending id order, each with a
// sorted member list. Depends on sgmt_pkg, sgmt_cell and sgmt_ram.
//
// One operation is taken per start beat while busy is low; its single result
// appears on the o_ result ports for exactly one cycle, marked by o_valid, and
// the receiver cannot stall it. The groups live in a chain of MAX_GROUPS cells.
// Every operation first rotates the whole chain once round while the head cell
// is compared with the group id. A register operation then inserts the new
// group, each cell shifting locally. Member operations work on a row of the
// member RAM through its single read and write port: the sorted scan reads and
// then compares one member at a time, and shifting the row up or down reads and
// then writes one member at a time. Busy rises after the start beat is taken
// and stays high up to the cycle of the result beat; in that cycle busy is
// already low and the next start beat may be taken. Each group keeps the number
// of the RAM row given to it when it was registered, so its members never move
// when groups shift. The RAM needs no clearing: only entries below a group's
// member count are ever read. The limit register lies at address 0.
`default_nettype none

module sorted_group_membership_table #(
    parameter int unsigned MAX_GROUPS  = sgmt_pkg::MAX_GROUPS_DEF,
    parameter int unsigned MAX_MEMBERS = sgmt_pkg::MAX_MEMBERS_DEF,
    localparam int unsigned SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    localparam int unsigned GW = $clog2(MAX_GROUPS + 1),
    localparam int unsigned CW = $clog2(MAX_MEMBERS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [2:0]    i_func,
    input  wire logic [63:0]   i_group_id,
    input  wire logic [63:0]   i_person_id,
    input  wire logic [63:0]   i_residence_ref,
    input  wire logic [63:0]   i_pool_ref,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic [63:0]        o_found_residence_ref,
    output logic [63:0]        o_found_pool_ref,
    output logic [CW-1:0]      o_member_total,
    output logic [GW-1:0]      o_group_total,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned DEPTH = MAX_GROUPS * MAX_MEMBERS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Chain signals, one element per cell, each read at its own place.
    logic          e_valid [MAX_GROUPS];
    logic [63:0]   e_id    [MAX_GROUPS];
    logic [63:0]   e_res   [MAX_GROUPS];
    logic [63:0]   e_pool  [MAX_GROUPS];
    logic [SW-1:0] e_slot  [MAX_GROUPS];
    logic [CW-1:0] e_cnt   [MAX_GROUPS];
    logic          e_lt    [MAX_GROUPS];

    sgmt_pkg::t_cell_ctrl w_ctrl;
    logic [CW-1:0]        w_upd_cnt;

    sgmt_pkg::t_state  r_state, n_state;
    logic [2:0]        r_func, n_func;
    logic [63:0]       r_gid, n_gid;
    logic [63:0]       r_pid, n_pid;
    logic [63:0]       r_res_in, n_res_in;
    logic [63:0]       r_pool_in, n_pool_in;
    logic [SW-1:0]     r_ctr, n_ctr;
    logic              r_hit, n_hit;
    logic [SW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [63:0]       r_fres, n_fres;
    logic [63:0]       r_fpool, n_fpool;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic              r_eq, n_eq;
    sgmt_pkg::t_status r_status, n_status;
    logic              r_found, n_found;
    logic [CW-1:0]     r_mcnt, n_mcnt;
    logic [GW-1:0]     r_gcnt, n_gcnt;
    logic [6:0]        r_limit;
    logic              r_ov, n_ov;
    logic [2:0]        r_o_status, n_o_status;
    logic              r_o_found, n_o_found;
    logic [63:0]       r_o_res, n_o_res;
    logic [63:0]       r_o_pool, n_o_pool;
    logic [CW-1:0]     r_o_mcnt, n_o_mcnt;
    logic [GW-1:0]     r_o_gcnt, n_o_gcnt;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [63:0]       w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [63:0]       w_rdata;
    logic [31:0]       w_lim;
    logic              w_full;

    // Address of member j in the RAM row owned by a group.
    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] s, input logic [CW-1:0] j);
        f_addr = AW'(32'(s) * MAX_MEMBERS + 32'(j));
    endfunction

    // The chain. Cell 0 sees a "less than" neighbour so that it takes a new
    // group when every stored id is larger. Cell 0 rotates into the last cell.
    for (genvar k = 0; k < MAX_GROUPS; k++) begin : g_cell
        localparam int unsigned PK = (k == 0) ? 0 : k - 1;
        localparam int unsigned NK = (k == MAX_GROUPS - 1) ? 0 : k + 1;

        sgmt_cell #(.SW(SW), .CW(CW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_gid        (r_gid),
            .i_new_res    (r_res_in),
            .i_new_pool   (r_pool_in),
            .i_new_slot   (SW'(r_gcnt)),
            .i_new_cnt    (w_upd_cnt),
            .i_prev_lt    ((k == 0) ? 1'b1 : e_lt[PK]),
            .i_prev_valid (e_valid[PK]),
            .i_prev_id    (e_id[PK]),
            .i_prev_res   (e_res[PK]),
            .i_prev_pool  (e_pool[PK]),
            .i_prev_slot  (e_slot[PK]),
            .i_prev_cnt   (e_cnt[PK]),
            .i_next_valid (e_valid[NK]),
            .i_next_id    (e_id[NK]),
            .i_next_res   (e_res[NK]),
            .i_next_pool  (e_pool[NK]),
            .i_next_slot  (e_slot[NK]),
            .i_next_cnt   (e_cnt[NK]),
            .o_lt         (e_lt[k]),
            .o_valid      (e_valid[k]),
            .o_id         (e_id[k]),
            .o_res        (e_res[k]),
            .o_pool       (e_pool[k]),
            .o_slot       (e_slot[k]),
            .o_cnt        (e_cnt[k])
        );
    end

    sgmt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_members (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A limit above the table depth acts as the depth.
    assign w_lim  = (32'(r_limit) > MAX_GROUPS) ? 32'(MAX_GROUPS) : 32'(r_limit);
    assign w_full = 32'(r_gcnt) >= w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgmt_pkg::S_IDLE;
            r_gcnt  <= '0;
            r_limit <= sgmt_pkg::LIMIT_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gcnt  <= n_gcnt;
            r_ov    <= n_ov;
            if (psel && penable && pwrite && (paddr == sgmt_pkg::ADDR_LIMIT)) begin
                r_limit <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_gid      <= n_gid;
        r_pid      <= n_pid;
        r_res_in   <= n_res_in;
        r_pool_in  <= n_pool_in;
        r_ctr      <= n_ctr;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
        r_fres     <= n_fres;
        r_fpool    <= n_fpool;
        r_i        <= n_i;
        r_j        <= n_j;
        r_eq       <= n_eq;
        r_status   <= n_status;
        r_found    <= n_found;
        r_mcnt     <= n_mcnt;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_res    <= n_o_res;
        r_o_pool   <= n_o_pool;
        r_o_mcnt   <= n_o_mcnt;
        r_o_gcnt   <= n_o_gcnt;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_gid      = r_gid;
        n_pid      = r_pid;
        n_res_in   = r_res_in;
        n_pool_in  = r_pool_in;
        n_ctr      = r_ctr;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_fres     = r_fres;
        n_fpool    = r_fpool;
        n_i        = r_i;
        n_j        = r_j;
        n_eq       = r_eq;
        n_status   = r_status;
        n_found    = r_found;
        n_mcnt     = r_mcnt;
        n_gcnt     = r_gcnt;
        n_ov       = 1'b0;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_res    = r_o_res;
        n_o_pool   = r_o_pool;
        n_o_mcnt   = r_o_mcnt;
        n_o_gcnt   = r_o_gcnt;
        w_ctrl     = '0;
        w_upd_cnt  = r_cnt;
        w_we       = 1'b0;
        w_waddr    = f_addr(r_slot, r_j);
        w_wdata    = w_rdata;
        w_raddr    = f_addr(r_slot, r_i);

        unique case (r_state)
            sgmt_pkg::S_IDLE: begin
                if (start) begin
                    n_func    = i_func;
                    n_gid     = i_group_id;
                    n_pid     = i_person_id;
                    n_res_in  = i_residence_ref;
                    n_pool_in = i_pool_ref;
                    n_hit     = 1'b0;
                    n_ctr     = '0;
                    n_found   = 1'b0;
                    n_status  = sgmt_pkg::STAT_OK;
                    n_state   = sgmt_pkg::S_GSCAN;
                end
            end
            // Walk the chain once round, looking at the head cell each cycle.
            sgmt_pkg::S_GSCAN: begin
                w_ctrl.rotate = 1'b1;
                if (e_valid[0] && (e_id[0] == r_gid)) begin
                    n_hit   = 1'b1;
                    n_slot  = e_slot[0];
                    n_cnt   = e_cnt[0];
                    n_fres  = e_res[0];
                    n_fpool = e_pool[0];
                end
                if (r_ctr == SW'(MAX_GROUPS - 1)) begin
                    n_state = sgmt_pkg::S_DECIDE;
                end else begin
                    n_ctr = r_ctr + 1'b1;
                end
            end
            sgmt_pkg::S_DECIDE: begin
                n_mcnt  = r_hit ? r_cnt : '0;
                n_i     = '0;
                n_eq    = 1'b0;
                n_state = sgmt_pkg::S_DONE;
                case (r_func) inside
                    sgmt_pkg::FN_REGISTER: begin
                        if (w_full) begin
                            n_status = sgmt_pkg::STAT_TABLE_FULL;
                        end else if (r_hit) begin
                            n_status = sgmt_pkg::STAT_DUPLICATE;
                        end else begin
                            w_ctrl.ins = 1'b1;
                            n_gcnt     = r_gcnt + 1'b1;
                            n_hit      = 1'b1;
                            n_mcnt     = '0;
                        end
                    end
                    sgmt_pkg::FN_ADD, sgmt_pkg::FN_REMOVE, sgmt_pkg::FN_HAS,
                    sgmt_pkg::FN_FIND: begin
                        if (!r_hit) begin
                            n_status = sgmt_pkg::STAT_NOT_FOUND;
                        end else if (r_func == sgmt_pkg::FN_FIND) begin
                            n_found = 1'b1;
                        end else if ((r_func == sgmt_pkg::FN_ADD) &&
                                     (32'(r_cnt) >= MAX_MEMBERS)) begin
                            n_status = sgmt_pkg::STAT_GROUP_FULL;
                        end else if (r_cnt == '0) begin
                            n_state = sgmt_pkg::S_MOP;
                        end else begin
                            n_state = sgmt_pkg::S_MRD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sgmt_pkg::S_MRD: begin
                w_raddr = f_addr(r_slot, r_i);
                n_state = sgmt_pkg::S_MCMP;
            end
            // The scan stops at the first member not below the person id.
            sgmt_pkg::S_MCMP: begin
                if (w_rdata >= r_pid) begin
                    n_eq    = (w_rdata == r_pid);
                    n_state = sgmt_pkg::S_MOP;
                end else begin
                    n_i = r_i + 1'b1;
                    if ((r_i + 1'b1) == r_cnt) begin
                        n_state = sgmt_pkg::S_MOP;
                    end else begin
                        n_state = sgmt_pkg::S_MRD;
                    end
                end
            end
            sgmt_pkg::S_MOP: begin
                n_state = sgmt_pkg::S_DONE;
                case (r_func)
                    sgmt_pkg::FN_HAS: begin
                        n_found = r_eq;
                    end
                    sgmt_pkg::FN_ADD: begin
                        if (!r_eq) begin
                            n_j     = r_cnt;
                            n_state = sgmt_pkg::S_UP;
                        end
                    end
                    sgmt_pkg::FN_REMOVE: begin
                        if (!r_eq) begin
                            n_status = sgmt_pkg::STAT_ABSENT;
                        end else begin
                            n_j     = r_i + 1'b1;
                            n_state = sgmt_pkg::S_DN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Open a gap at the insertion point, moving from the top down.
            sgmt_pkg::S_UP: begin
                if (r_j > r_i) begin
                    w_raddr = f_addr(r_slot, r_j - 1'b1);
                    n_state = sgmt_pkg::S_UPWR;
                end else begin
                    w_we       = 1'b1;
                    w_waddr    = f_addr(r_slot, r_i);
                    w_wdata    = r_pid;
                    w_ctrl.upd = 1'b1;
                    w_upd_cnt  = r_cnt + 1'b1;
                    n_mcnt     = r_cnt + 1'b1;
                    n_state    = sgmt_pkg::S_DONE;
                end
            end
            sgmt_pkg::S_UPWR: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_slot, r_j);
                n_j     = r_j - 1'b1;
                n_state = sgmt_pkg::S_UP;
            end
            // Close the gap that the removed member leaves.
            sgmt_pkg::S_DN: begin
                if (r_j < r_cnt) begin
                    w_raddr = f_addr(r_slot, r_j);
                    n_state = sgmt_pkg::S_DNWR;
                end else begin
                    w_ctrl.upd = 1'b1;
                    w_upd_cnt  = r_cnt - 1'b1;
                    n_mcnt     = r_cnt - 1'b1;
                    n_state    = sgmt_pkg::S_DONE;
                end
            end
            sgmt_pkg::S_DNWR: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_slot, r_j - 1'b1);
                n_j     = r_j + 1'b1;
                n_state = sgmt_pkg::S_DN;
            end
            sgmt_pkg::S_DONE: begin
                n_ov       = 1'b1;
                n_o_status = r_status;
                n_o_found  = r_found;
                n_o_res    = (r_found && (r_func == sgmt_pkg::FN_FIND)) ? r_fres : '0;
                n_o_pool   = (r_found && (r_func == sgmt_pkg::FN_FIND)) ? r_fpool : '0;
                n_o_mcnt   = r_mcnt;
                n_o_gcnt   = r_gcnt;
                n_state    = sgmt_pkg::S_IDLE;
            end
            default: begin
                n_state = sgmt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy                  = (r_state != sgmt_pkg::S_IDLE);
    assign o_valid               = r_ov;
    assign o_status              = r_o_status;
    assign o_found               = r_o_found;
    assign o_found_residence_ref = r_o_res;
    assign o_found_pool_ref      = r_o_pool;
    assign o_member_total        = r_o_mcnt;
    assign o_group_total         = r_o_gcnt;
    assign prdata                = (paddr == sgmt_pkg::ADDR_LIMIT) ? {25'd0, r_limit} : 32'd0;
    assign pready                = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/sgmt_checker.sv =====
// Port-level checks of the sorted group membership table, bound to the top.
// Depends on sgmt_pkg and the assertion macro header.
`default_nettype none
`include "sorted_group_membership_table_macros.svh"

module sgmt_checker #(
    parameter int unsigned MAX_GROUPS  = sgmt_pkg::MAX_GROUPS_DEF,
    parameter int unsigned MAX_MEMBERS = sgmt_pkg::MAX_MEMBERS_DEF,
    localparam int unsigned GW = $clog2(MAX_GROUPS + 1),
    localparam int unsigned CW = $clog2(MAX_MEMBERS + 1)
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_valid,
    input wire logic [2:0]    o_status,
    input wire logic          o_found,
    input wire logic [63:0]   o_found_residence_ref,
    input wire logic [63:0]   o_found_pool_ref,
    input wire logic [CW-1:0] o_member_total,
    input wire logic [GW-1:0] o_group_total
);

    logic w_found_beat;
    logic w_miss_beat;
    logic w_found_ok;
    logic w_refs_zero;
    logic w_totals_ok;

    assign w_found_beat = o_valid && o_found;
    assign w_miss_beat  = o_valid && !o_found;
    assign w_found_ok   = (o_status == sgmt_pkg::STAT_OK);
    assign w_refs_zero  = (o_found_residence_ref == 64'd0) && (o_found_pool_ref == 64'd0);
    assign w_totals_ok  = (32'(o_group_total) <= MAX_GROUPS) &&
                          (32'(o_member_total) <= MAX_MEMBERS);

    // A result beat ends the operation, so the block is free again.
    `SGMT_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_valid, !busy)
    // An accepted start beat makes the block busy.
    `SGMT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // Only a successful lookup reports a hit.
    `SGMT_ASSERT_SAME(a_found_ok, i_clk, i_rst_n, w_found_beat, w_found_ok)
    // References are zero unless a group was found.
    `SGMT_ASSERT_SAME(a_refs_zero, i_clk, i_rst_n, w_miss_beat, w_refs_zero)
    // Counts never pass the table dimensions.
    `SGMT_ASSERT_SAME(a_totals, i_clk, i_rst_n, o_valid, w_totals_ok)

endmodule

bind sorted_group_membership_table sgmt_checker #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_MEMBERS (MAX_MEMBERS)
) u_sgmt_checker (.*);

`default_nettype wire

// ===== tb/sv/sorted_group_membership_table_test.sv =====
// Self-checking testbench for the sorted group membership table.
// Depends on sgmt_pkg and the sorted_group_membership_table RTL only.
module sorted_group_membership_table_test;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] res_ref;
        logic [63:0] pool_ref;
        logic [4:0]  member_total;
        logic [6:0]  group_total;
    } t_op_result;

    localparam int NGROUPS  = sgmt_pkg::MAX_GROUPS_DEF;
    localparam int NMEMBERS = sgmt_pkg::MAX_MEMBERS_DEF;
    localparam int IDLE_CYCLES_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 160;
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [63:0] i_group_id;
    logic [63:0] i_person_id;
    logic [63:0] i_residence_ref;
    logic [63:0] i_pool_ref;
    logic        o_valid;
    logic [2:0]  o_status;
    logic        o_found;
    logic [63:0] o_found_residence_ref;
    logic [63:0] o_found_pool_ref;
    logic [4:0]  o_member_total;
    logic [6:0]  o_group_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sorted_group_membership_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_group_id(i_group_id), .i_person_id(i_person_id),
        .i_residence_ref(i_residence_ref), .i_pool_ref(i_pool_ref),
        .o_valid(o_valid), .o_status(o_status), .o_found(o_found),
        .o_found_residence_ref(o_found_residence_ref),
        .o_found_pool_ref(o_found_pool_ref),
        .o_member_total(o_member_total), .o_group_total(o_group_total),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the table, kept in sorted order exactly as the block keeps it.
    logic [63:0] shadow_gid   [NGROUPS];
    logic [63:0] shadow_res   [NGROUPS];
    logic [63:0] shadow_pool  [NGROUPS];
    int          shadow_cnt   [NGROUPS];
    logic [63:0] shadow_mem   [NGROUPS][NMEMBERS];
    int          shadow_groups;
    logic [6:0]  shadow_limit;

    t_op_result  pending_results[$];
    int          error_count;
    int          quiet_cycles;
    bit          gaps_enabled;
    logic [63:0] gid_pool[72];
    logic [63:0] pid_pool[24];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Works out the result of one operation and updates the shadow table.
    function automatic t_op_result apply_table_op(logic [2:0] fn, logic [63:0] gid,
                                                  logic [63:0] pid, logic [63:0] res,
                                                  logic [63:0] pool);
        t_op_result r;
        int g, i, j, n, lim;
        bit hit, present;
        r = '0;
        lim = (shadow_limit > NGROUPS) ? NGROUPS : shadow_limit;
        hit = 1'b0;
        for (g = 0; g < shadow_groups; g++) begin
            if (shadow_gid[g] == gid) begin
                hit = 1'b1;
                break;
            end
            if (shadow_gid[g] > gid) break;
        end
        if (fn == sgmt_pkg::FN_REGISTER) begin
            // A full table is refused before the duplicate check is made.
            if (shadow_groups >= lim) r.status = sgmt_pkg::STAT_TABLE_FULL;
            else if (hit) r.status = sgmt_pkg::STAT_DUPLICATE;
            else begin
                for (i = shadow_groups; i > g; i--) begin
                    shadow_gid[i]  = shadow_gid[i-1];
                    shadow_res[i]  = shadow_res[i-1];
                    shadow_pool[i] = shadow_pool[i-1];
                    shadow_cnt[i]  = shadow_cnt[i-1];
                    shadow_mem[i]  = shadow_mem[i-1];
                end
                shadow_gid[g] = gid;
                shadow_res[g] = res;
                shadow_pool[g] = pool;
                shadow_cnt[g] = 0;
                shadow_groups++;
                hit = 1'b1;
            end
        end else if (fn inside {sgmt_pkg::FN_ADD, sgmt_pkg::FN_REMOVE, sgmt_pkg::FN_HAS,
                                sgmt_pkg::FN_FIND}) begin
            if (!hit) r.status = sgmt_pkg::STAT_NOT_FOUND;
            else begin
                n = shadow_cnt[g];
                for (i = 0; i < n; i++)
                    if (shadow_mem[g][i] >= pid) break;
                present = (i < n) && (shadow_mem[g][i] == pid);
                case (fn)
                    sgmt_pkg::FN_ADD: begin
                        // A full group refuses even a person already listed.
                        if (n >= NMEMBERS) r.status = sgmt_pkg::STAT_GROUP_FULL;
                        else if (!present) begin
                            for (j = n; j > i; j--) shadow_mem[g][j] = shadow_mem[g][j-1];
                            shadow_mem[g][i] = pid;
                            shadow_cnt[g] = n + 1;
                        end
                    end
                    sgmt_pkg::FN_REMOVE: begin
                        if (present) begin
                            for (j = i + 1; j < n; j++) shadow_mem[g][j-1] = shadow_mem[g][j];
                            shadow_cnt[g] = n - 1;
                        end else r.status = sgmt_pkg::STAT_ABSENT;
                    end
                    sgmt_pkg::FN_HAS: r.found = present;
                    default: begin
                        r.found = 1'b1;
                        r.res_ref = shadow_res[g];
                        r.pool_ref = shadow_pool[g];
                    end
                endcase
            end
        end
        r.member_total = hit ? shadow_cnt[g][4:0] : 5'd0;
        r.group_total = shadow_groups[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Checks every result beat against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_op_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 64'd0, 64'd0);
            else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_found_residence_ref !== want.res_ref)
                    report_mismatch("residence ref", o_found_residence_ref, want.res_ref);
                if (o_found_pool_ref !== want.pool_ref)
                    report_mismatch("pool ref", o_found_pool_ref, want.pool_ref);
                if (o_member_total !== want.member_total)
                    report_mismatch("member total", o_member_total, want.member_total);
                if (o_group_total !== want.group_total)
                    report_mismatch("group total", o_group_total, want.group_total);
            end
        end
    end

    // Watchdog: ends the run if nothing at all is accepted for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_CYCLES_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one command beat, with an occasional random gap in front of it.
    task automatic send_op(logic [2:0] fn, logic [63:0] gid, logic [63:0] pid,
                           logic [63:0] res, logic [63:0] pool);
        while (gaps_enabled && $urandom_range(99) < 6) @(negedge i_clk);
        @(negedge i_clk);
        start <= 1'b1;
        i_func <= fn;
        i_group_id <= gid;
        i_person_id <= pid;
        i_residence_ref <= res;
        i_pool_ref <= pool;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_table_op(fn, gid, pid, res, pool));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the group limit over the register port, then reads it back.
    task automatic write_limit(logic [6:0] value);
        wait_idle();
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= sgmt_pkg::ADDR_LIMIT; pwdata <= {25'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_limit = value;
        @(negedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[6:0] !== value) report_mismatch("limit readback", prdata[6:0], value);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // Edge cases on a nearly empty table: extreme ids, duplicates, a full group.
    task automatic test_directed();
        int k;
        send_op(sgmt_pkg::FN_FIND, 64'd0, 64'd0, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_ADD, '1, 64'd5, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_REGISTER, '1, 64'd0, 64'h5555_5555_5555_5555, '1);
        send_op(sgmt_pkg::FN_REGISTER, 64'd0, 64'd0, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(sgmt_pkg::FN_REGISTER, '1, 64'd0, 64'd1, 64'd2);
        send_op(sgmt_pkg::FN_REGISTER, 64'h8000_0000_0000_0000, '1, rand64(), rand64());
        send_op(sgmt_pkg::FN_ADD, 64'd0, '1, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_ADD, 64'd0, 64'd0, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_ADD, 64'd0, '1, 64'd0, 64'd0);
        for (k = 1; k < 15; k++)
            send_op(sgmt_pkg::FN_ADD, 64'd0, 64'd100 - k, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_ADD, 64'd0, 64'd50, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_ADD, 64'd0, '1, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_HAS, 64'd0, 64'd90, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_HAS, 64'd0, 64'd7, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_REMOVE, 64'd0, 64'd7, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_REMOVE, '1, 64'd3, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_FIND, '1, 64'd0, 64'd0, 64'd0);
        send_op(sgmt_pkg::FN_HAS, 64'd12, 64'd0, 64'd0, 64'd0);
        send_op(FN_SPARE_LO, 64'd0, 64'd0, 64'd0, 64'd0);
        send_op(FN_SPARE_HI, '1, '1, '1, '1);
    endtask

    // Lowering the limit below the count keeps every group but refuses registers; raising it admits them again.
    task automatic test_limit_settings();
        write_limit(7'd2);
        send_op(sgmt_pkg::FN_REGISTER, 64'd77, 64'd0, 64'd1, 64'd1);
        send_op(sgmt_pkg::FN_REGISTER, 64'd0, 64'd0, 64'd1, 64'd1);
        send_op(sgmt_pkg::FN_FIND, '1, 64'd0, 64'd0, 64'd0);
        write_limit(7'd0);
        send_op(sgmt_pkg::FN_REGISTER, 64'd78, 64'd0, 64'd1, 64'd1);
        write_limit(7'd127);
        send_op(sgmt_pkg::FN_REGISTER, 64'd79, 64'd0, 64'd3, 64'd4);
        write_limit(7'd5);
        send_op(sgmt_pkg::FN_REGISTER, 64'd80, 64'd0, 64'd5, 64'd6);
        send_op(sgmt_pkg::FN_REGISTER, 64'd81, 64'd0, 64'd5, 64'd6);
    endtask

    // Mostly well-formed traffic on a pool of known ids, with some noise mixed in.
    task automatic test_random(int count, logic [6:0] lim);
        int k, pick;
        logic [2:0] fn;
        logic [63:0] gid, pid;
        write_limit(lim);
        for (k = 0; k < count; k++) begin
            gaps_enabled = !(k >= count / 3 && k < count / 2);
            pick = $urandom_range(99);
            if (pick < 15) fn = sgmt_pkg::FN_REGISTER;
            else if (pick < 50) fn = sgmt_pkg::FN_ADD;
            else if (pick < 68) fn = sgmt_pkg::FN_REMOVE;
            else if (pick < 84) fn = sgmt_pkg::FN_HAS;
            else if (pick < 95) fn = sgmt_pkg::FN_FIND;
            else fn = 3'($urandom_range(5, 7));
            gid = ($urandom_range(19) == 0) ? rand64() : gid_pool[$urandom_range(71)];
            pid = ($urandom_range(19) == 0) ? rand64() : pid_pool[$urandom_range(23)];
            send_op(fn, gid, pid, rand64(), rand64());
            if (k == count / 2) wait_idle();
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = '0; i_group_id = '0; i_person_id = '0;
        i_residence_ref = '0; i_pool_ref = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        quiet_cycles = 0;
        gaps_enabled = 1'b1;
        shadow_groups = 0;
        shadow_limit = sgmt_pkg::LIMIT_RESET;
        for (k = 0; k < 72; k++) gid_pool[k] = rand64();
        gid_pool[0] = 64'd0;
        gid_pool[1] = '1;
        gid_pool[2] = 64'd1;
        for (k = 0; k < 24; k++) pid_pool[k] = rand64();
        pid_pool[0] = 64'd0;
        pid_pool[1] = '1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limit_settings();
        test_random(450, 7'd64);
        test_random(450, 7'd127);

        wait_idle();
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
